[hdl/sapd_pkg.sv]
`timescale 1ns / 1ps
package sapd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int ACC_W       = 46;
   localparam int CHUNK_W     = 23;
   localparam int MUL_W       = 24;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int WIDE_W      = 2 * ACC_W + 2;
   localparam int REM_W       = WIDE_W + 1;
   localparam int Q_W         = 32;
   localparam int CORR_W      = 16;
   localparam int CNT_W       = 5;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int LEN_REG_W   = 13;

   localparam logic [CSR_IDX_W-1:0] REG_SYMBOL_LENGTH    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DETECT_THRESHOLD = 8'd1;
   localparam logic [LEN_REG_W-1:0] SYMBOL_LENGTH_RESET  = 13'd1024;
   localparam logic [CORR_W-1:0]    THRESHOLD_RESET      = 16'd58982;

   localparam logic [CNT_W-1:0] MAC_LAST_PREV  = 5'd5;
   localparam logic [CNT_W-1:0] MAC_LAST_FIRST = 5'd1;
   localparam logic [CNT_W-1:0] NORM_LAST      = 5'd11;
   localparam logic [CNT_W-1:0] DIV_LAST       = 5'd31;
   localparam logic [CNT_W-1:0] SQRT_LAST      = 5'd15;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_i;
      logic signed [SAMPLE_BITS-1:0] sample_q;
   } req_payload_type;

   typedef struct packed {
      logic [CORR_W-1:0] correlation;
      logic              detected;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ACC_NONE, ACC_E, ACC_DR, ACC_DI, ACC_DI_SUB, ACC_NUM, ACC_DEN
   } acc_type;

   typedef enum logic [3:0] {
      SEL_CI, SEL_CQ, SEL_PI, SEL_PQ,
      SEL_DRL, SEL_DRH, SEL_DIL, SEL_DIH,
      SEL_EPL, SEL_EPH, SEL_ECL, SEL_ECH
   } sel_type;

   typedef struct packed {
      acc_type     acc;
      sel_type     sel_a;
      sel_type     sel_b;
      logic [1:0]  sh;
   } mul_op_type;

   typedef struct packed {
      mul_op_type mul;
      logic       load;
      logic       clr_nd;
      logic       div_init;
      logic       div_step;
      logic       sq_init;
      logic       sq_step;
      logic       corr_special;
      logic       corr_root;
      logic       out_load;
      logic       roll;
   } cmd_type;

   typedef struct packed {
      logic den_zero;
      logic num_ge;
      logic out_free;
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_MAC, S_MDRAIN, S_NMUL, S_NDRAIN, S_NCHK,
      S_DIV, S_SQI, S_SQRT, S_SQD, S_OUT, S_ROLL
   } state_type;

   localparam mul_op_type MUL_NOP = '{ACC_NONE, SEL_CI, SEL_CI, 2'd0};

   function automatic mul_op_type mac_op(input logic [CNT_W-1:0] k);
      mul_op_type o;
      o = MUL_NOP;
      case (k)
         5'd0: o = '{ACC_E,      SEL_CI, SEL_CI, 2'd0};
         5'd1: o = '{ACC_E,      SEL_CQ, SEL_CQ, 2'd0};
         5'd2: o = '{ACC_DR,     SEL_PI, SEL_CI, 2'd0};
         5'd3: o = '{ACC_DR,     SEL_PQ, SEL_CQ, 2'd0};
         5'd4: o = '{ACC_DI,     SEL_PQ, SEL_CI, 2'd0};
         5'd5: o = '{ACC_DI_SUB, SEL_PI, SEL_CQ, 2'd0};
         default: o = MUL_NOP;
      endcase
      return o;
   endfunction

   // partial products of |dr|^2 + |di|^2 and eprev * ecur, 23-bit halves
   function automatic mul_op_type norm_op(input logic [CNT_W-1:0] k);
      mul_op_type o;
      o = MUL_NOP;
      case (k)
         5'd0:  o = '{ACC_NUM, SEL_DRL, SEL_DRL, 2'd0};
         5'd1:  o = '{ACC_NUM, SEL_DRL, SEL_DRH, 2'd1};
         5'd2:  o = '{ACC_NUM, SEL_DRH, SEL_DRL, 2'd1};
         5'd3:  o = '{ACC_NUM, SEL_DRH, SEL_DRH, 2'd2};
         5'd4:  o = '{ACC_NUM, SEL_DIL, SEL_DIL, 2'd0};
         5'd5:  o = '{ACC_NUM, SEL_DIL, SEL_DIH, 2'd1};
         5'd6:  o = '{ACC_NUM, SEL_DIH, SEL_DIL, 2'd1};
         5'd7:  o = '{ACC_NUM, SEL_DIH, SEL_DIH, 2'd2};
         5'd8:  o = '{ACC_DEN, SEL_EPL, SEL_ECL, 2'd0};
         5'd9:  o = '{ACC_DEN, SEL_EPL, SEL_ECH, 2'd1};
         5'd10: o = '{ACC_DEN, SEL_EPH, SEL_ECL, 2'd1};
         5'd11: o = '{ACC_DEN, SEL_EPH, SEL_ECH, 2'd2};
         default: o = MUL_NOP;
      endcase
      return o;
   endfunction

endpackage

[hdl/sapd_ram.sv]
`timescale 1ns / 1ps
module sapd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/sapd_dpath.sv]
`timescale 1ns / 1ps
module sapd_dpath import sapd_pkg::*; #(
   parameter int MAX_SYMBOL_LEN = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cmd_type                           cmd,
   input  logic                              restart,
   input  logic [$clog2(MAX_SYMBOL_LEN)-1:0] addr,
   input  req_payload_type                   req_payload,
   input  logic [CORR_W-1:0]                 threshold,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output rsp_payload_type                   rsp_payload,
   output status_type                        status
);

   logic signed [SAMPLE_BITS-1:0] ci_ff, cq_ff, pi, pq;
   logic [2*SAMPLE_BITS-1:0]      rd_word;

   logic signed [ACC_W-1:0] dr_ff, dr_in, di_ff, di_in;
   logic [ACC_W-1:0]        ep_ff, ep_in, ec_ff, ec_in, dr_mag, di_mag;
   logic [WIDE_W-1:0]       num_ff, num_in, den_ff, den_in, part;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   acc_type                 acc_ff, acc_in;
   logic [1:0]              sh_ff, sh_in;
   logic signed [MUL_W-1:0] op_a, op_b;

   logic [REM_W-1:0] rem_ff, rem_in, rem_sh;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [Q_W-1:0]   sx_ff, sx_in, sres_ff, sres_in, sbit_ff, sbit_in, trial;
   logic [CORR_W-1:0] corr_ff, corr_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   // the old sample at this position is read on the same edge that overwrites it
   sapd_ram #(.WIDTH(2 * SAMPLE_BITS), .DEPTH(MAX_SYMBOL_LEN)) u_prev (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (addr),
      .wr_data ({req_payload.sample_i, req_payload.sample_q}),
      .rd_en   (cmd.load),
      .rd_addr (addr),
      .rd_data (rd_word)
   );

   assign pi = rd_word[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign pq = rd_word[SAMPLE_BITS-1:0];

   assign dr_mag = dr_ff[ACC_W-1] ? ACC_W'(-dr_ff) : ACC_W'(dr_ff);
   assign di_mag = di_ff[ACC_W-1] ? ACC_W'(-di_ff) : ACC_W'(di_ff);

   function automatic logic signed [MUL_W-1:0] pick(
      input sel_type s,
      input logic signed [SAMPLE_BITS-1:0] a_ci, a_cq, a_pi, a_pq,
      input logic [ACC_W-1:0] a_dr, a_di, a_ep, a_ec);
      logic signed [MUL_W-1:0] v;
      v = '0;
      case (s)
         SEL_CI:  v = MUL_W'(a_ci);
         SEL_CQ:  v = MUL_W'(a_cq);
         SEL_PI:  v = MUL_W'(a_pi);
         SEL_PQ:  v = MUL_W'(a_pq);
         SEL_DRL: v = {1'b0, a_dr[CHUNK_W-1:0]};
         SEL_DRH: v = {1'b0, a_dr[ACC_W-1:CHUNK_W]};
         SEL_DIL: v = {1'b0, a_di[CHUNK_W-1:0]};
         SEL_DIH: v = {1'b0, a_di[ACC_W-1:CHUNK_W]};
         SEL_EPL: v = {1'b0, a_ep[CHUNK_W-1:0]};
         SEL_EPH: v = {1'b0, a_ep[ACC_W-1:CHUNK_W]};
         SEL_ECL: v = {1'b0, a_ec[CHUNK_W-1:0]};
         SEL_ECH: v = {1'b0, a_ec[ACC_W-1:CHUNK_W]};
         default: v = '0;
      endcase
      return v;
   endfunction

   assign op_a = pick(cmd.mul.sel_a, ci_ff, cq_ff, pi, pq, dr_mag, di_mag, ep_ff, ec_ff);
   assign op_b = pick(cmd.mul.sel_b, ci_ff, cq_ff, pi, pq, dr_mag, di_mag, ep_ff, ec_ff);
   assign prod_in = op_a * op_b;
   assign acc_in  = cmd.mul.acc;
   assign sh_in   = cmd.mul.sh;

   always_comb begin
      case (sh_ff)
         2'd1:    part = WIDE_W'(prod_ff[2*CHUNK_W-1:0]) << CHUNK_W;
         2'd2:    part = WIDE_W'(prod_ff[2*CHUNK_W-1:0]) << (2 * CHUNK_W);
         default: part = WIDE_W'(prod_ff[2*CHUNK_W-1:0]);
      endcase
   end

   assign rem_sh = {rem_ff[REM_W-2:0], 1'b0};
   assign trial  = sres_ff + sbit_ff;

   always_comb begin
      dr_in = dr_ff;
      di_in = di_ff;
      ep_in = ep_ff;
      ec_in = ec_ff;
      num_in = num_ff;
      den_in = den_ff;
      case (acc_ff)
         ACC_E:      ec_in  = ec_ff + prod_ff[ACC_W-1:0];
         ACC_DR:     dr_in  = dr_ff + ACC_W'(prod_ff);
         ACC_DI:     di_in  = di_ff + ACC_W'(prod_ff);
         ACC_DI_SUB: di_in  = di_ff - ACC_W'(prod_ff);
         ACC_NUM:    num_in = num_ff + part;
         ACC_DEN:    den_in = den_ff + part;
         default: ;
      endcase
      if (cmd.clr_nd) begin
         num_in = '0;
         den_in = '0;
      end
      if (cmd.roll) begin
         ep_in = ec_ff;
         ec_in = '0;
         dr_in = '0;
         di_in = '0;
      end
      if (restart) begin
         ep_in = '0;
         ec_in = '0;
         dr_in = '0;
         di_in = '0;
      end

      rem_in = rem_ff;
      q_in   = q_ff;
      if (cmd.div_init) begin
         rem_in = REM_W'(num_ff);
         q_in   = '0;
      end else if (cmd.div_step) begin
         if (rem_sh >= REM_W'(den_ff)) begin
            rem_in = rem_sh - REM_W'(den_ff);
            q_in   = {q_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[Q_W-2:0], 1'b0};
         end
      end

      // bitwise integer square root, two bits of the radicand per step
      sx_in   = sx_ff;
      sres_in = sres_ff;
      sbit_in = sbit_ff;
      if (cmd.sq_init) begin
         sx_in   = q_ff;
         sres_in = '0;
         sbit_in = Q_W'(1) << (Q_W - 2);
      end else if (cmd.sq_step) begin
         if (sx_ff >= trial) begin
            sx_in   = sx_ff - trial;
            sres_in = (sres_ff >> 1) + sbit_ff;
         end else begin
            sres_in = sres_ff >> 1;
         end
         sbit_in = sbit_ff >> 2;
      end

      corr_in = corr_ff;
      if (cmd.corr_special) begin
         corr_in = status.den_zero ? '0 : '1;
      end else if (cmd.corr_root) begin
         corr_in = sres_ff[CORR_W-1:0];
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) begin
         rsp_in.correlation = corr_ff;
         rsp_in.detected    = (corr_ff >= threshold);
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ci_ff <= req_payload.sample_i;
         cq_ff <= req_payload.sample_q;
      end
      prod_ff <= prod_in;
      sh_ff   <= sh_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      sx_ff   <= sx_in;
      sres_ff <= sres_in;
      sbit_ff <= sbit_in;
      corr_ff <= corr_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= ACC_NONE;
         dr_ff        <= '0;
         di_ff        <= '0;
         ep_ff        <= '0;
         ec_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         dr_ff        <= dr_in;
         di_ff        <= di_in;
         ep_ff        <= ep_in;
         ec_ff        <= ec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.den_zero = (den_ff == '0);
   assign status.num_ge   = (num_ff >= den_ff);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // a waiting word is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.out_load && rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   // roll leaves the current energy in the previous-energy register
   assert property (@(posedge clock) disable iff (reset)
      (cmd.roll && !restart) |=> (ep_ff == $past(ec_ff)) && (ec_ff == '0))
      else $error("symbol roll lost energy");

   // the root of a 32-bit radicand fits the result field
   assert property (@(posedge clock) disable iff (reset)
      cmd.corr_root |-> (sres_ff[Q_W-1:CORR_W] == '0))
      else $error("square root out of range");

endmodule

[hdl/sapd_ctrl.sv]
`timescale 1ns / 1ps
module sapd_ctrl import sapd_pkg::*; #(
   parameter int MAX_SYMBOL_LEN = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              restart,
   input  logic [LEN_REG_W-1:0]              symbol_length,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  status_type                        status,
   output cmd_type                           cmd,
   output logic [$clog2(MAX_SYMBOL_LEN)-1:0] addr
);

   localparam int PW = $clog2(MAX_SYMBOL_LEN);
   localparam int LW = PW + 1;
   localparam logic [LEN_REG_W:0] MAX_LEN = (LEN_REG_W + 1)'(MAX_SYMBOL_LEN);
   localparam logic [LEN_REG_W:0] MIN_LEN = (LEN_REG_W + 1)'(2);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic              have_prev_ff, have_prev_in;
   logic [LEN_REG_W:0] len_ext, len_clamp;
   logic [LW-1:0]     len_eff;
   logic              last_sample;

   assign len_ext = {1'b0, symbol_length};
   assign len_clamp = (len_ext < MIN_LEN) ? MIN_LEN :
                      (len_ext > MAX_LEN) ? MAX_LEN : len_ext;
   assign len_eff = LW'(len_clamp);
   assign last_sample = (({1'b0, pos_ff} + LW'(1)) == len_eff);
   assign addr = pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         pos_ff       <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         pos_ff       <= pos_in;
         have_prev_ff <= have_prev_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      pos_in       = pos_ff;
      have_prev_in = have_prev_ff;
      cmd          = '0;
      cmd.mul      = MUL_NOP;
      req_stall    = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               k_in     = '0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            cmd.mul = mac_op(k_ff);
            k_in    = k_ff + CNT_W'(1);
            if (k_ff == (have_prev_ff ? MAC_LAST_PREV : MAC_LAST_FIRST)) begin
               state_in = S_MDRAIN;
            end
         end
         S_MDRAIN: begin
            if (!last_sample) begin
               pos_in   = pos_ff + PW'(1);
               state_in = S_IDLE;
            end else if (have_prev_ff) begin
               cmd.clr_nd = 1'b1;
               k_in       = '0;
               state_in   = S_NMUL;
            end else begin
               state_in = S_ROLL;
            end
         end
         S_NMUL: begin
            cmd.mul = norm_op(k_ff);
            k_in    = k_ff + CNT_W'(1);
            if (k_ff == NORM_LAST) begin
               state_in = S_NDRAIN;
            end
         end
         S_NDRAIN: begin
            state_in = S_NCHK;
         end
         S_NCHK: begin
            cmd.corr_special = 1'b1;
            cmd.div_init     = 1'b1;
            k_in             = '0;
            state_in = (status.den_zero || status.num_ge) ? S_OUT : S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            k_in         = k_ff + CNT_W'(1);
            if (k_ff == DIV_LAST) begin
               state_in = S_SQI;
            end
         end
         S_SQI: begin
            cmd.sq_init = 1'b1;
            k_in        = '0;
            state_in    = S_SQRT;
         end
         S_SQRT: begin
            cmd.sq_step = 1'b1;
            k_in        = k_ff + CNT_W'(1);
            if (k_ff == SQRT_LAST) begin
               state_in = S_SQD;
            end
         end
         S_SQD: begin
            cmd.corr_root = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_ROLL;
            end
         end
         S_ROLL: begin
            cmd.roll     = 1'b1;
            have_prev_in = 1'b1;
            pos_in       = '0;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // length rewrite restarts the symbol framing
      if (restart) begin
         pos_in       = '0;
         have_prev_in = 1'b0;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff == S_MAC))
      else $error("accepted word did not start the product sequence");

   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, pos_ff} < len_eff) || $past(restart))
      else $error("symbol position past symbol length");

   assert property (@(posedge clock) disable iff (reset)
      $fell(have_prev_ff) |-> $past(restart))
      else $error("previous symbol dropped without a restart");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NMUL) |-> have_prev_ff)
      else $error("normalization without a previous symbol");

endmodule

[hdl/symbol_autocorr_preamble_detect.sv]
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_payload: sample_i, sample_q
// rsp       out        rsp_valid / rsp_stall  rsp_payload: correlation, detected
// csr       in         csr_valid / csr_ready  csr_index, csr_wdata
//
// a sample runs 2 products in the first symbol and 6 afterward on the shared
// 24x24 multiplier, then an accumulate (drain) step
// a symbol end adds a roll step; with a previous symbol it first runs
// 12 partial products, drain, check, 32-step divider, 16-step root, load, roll
// (divider and root are skipped when the energy is zero or the ratio reaches one)
// reset is synchronous; state and the dot and energy accumulators clear, the sample store does not
// a stalled result word waits in the output register while sampling goes on;
// the next result holds the input until that word leaves
module symbol_autocorr_preamble_detect import sapd_pkg::*; #(
   parameter int MAX_SYMBOL_LEN = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PW = $clog2(MAX_SYMBOL_LEN);

   logic [LEN_REG_W-1:0] sym_len_ff, sym_len_in;
   logic [CORR_W-1:0]    thr_ff, thr_in;
   logic                 csr_wr, restart;
   cmd_type              cmd;
   status_type           status;
   logic [PW-1:0]        addr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign restart   = csr_wr && (csr_index == REG_SYMBOL_LENGTH);

   always_comb begin
      sym_len_in = sym_len_ff;
      thr_in     = thr_ff;
      if (restart) begin
         sym_len_in = csr_wdata[LEN_REG_W-1:0];
      end
      if (csr_wr && csr_index == REG_DETECT_THRESHOLD) begin
         thr_in = csr_wdata[CORR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_len_ff <= SYMBOL_LENGTH_RESET;
         thr_ff     <= THRESHOLD_RESET;
      end else begin
         sym_len_ff <= sym_len_in;
         thr_ff     <= thr_in;
      end
   end

   sapd_ctrl #(.MAX_SYMBOL_LEN(MAX_SYMBOL_LEN)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .restart       (restart),
      .symbol_length (sym_len_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd),
      .addr          (addr)
   );

   sapd_dpath #(.MAX_SYMBOL_LEN(MAX_SYMBOL_LEN)) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .restart     (restart),
      .addr        (addr),
      .req_payload (req_payload),
      .threshold   (thr_ff),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .status      (status)
   );

endmodule

[test/tb_symbol_autocorr_preamble_detect.sv]
`timescale 1ns / 1ps
module tb_symbol_autocorr_preamble_detect;
   import sapd_pkg::*;

   localparam int MAX_LEN = 4096;

   class corr_scoreboard;
      logic signed [15:0] prev_i [MAX_LEN];
      logic signed [15:0] prev_q [MAX_LEN];
      int unsigned sym_len;
      int unsigned thr;
      int unsigned pos;
      bit          have_prev;
      longint      dot_re, dot_im;
      bit [63:0]   e_prev, e_cur;
      rsp_payload_type pending [$];
      int          errors;

      function new();
         sym_len = SYMBOL_LENGTH_RESET;
         thr     = THRESHOLD_RESET;
         errors  = 0;
         restart();
      endfunction

      function void restart();
         pos = 0;
         have_prev = 0;
         dot_re = 0;
         dot_im = 0;
         e_prev = 0;
         e_cur = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == REG_SYMBOL_LENGTH) begin
            sym_len = val & 16'h1FFF;
            restart();
         end else if (idx == REG_DETECT_THRESHOLD) begin
            thr = val;
         end
      endfunction

      function bit [15:0] correlation_of();
         bit [127:0] num, den;
         bit [159:0] quot;
         bit [63:0]  mr, mi;
         bit [31:0]  q, root, t;
         mr = dot_re < 0 ? -dot_re : dot_re;
         mi = dot_im < 0 ? -dot_im : dot_im;
         num = 128'(mr) * 128'(mr) + 128'(mi) * 128'(mi);
         den = 128'(e_prev) * 128'(e_cur);
         if (den == 0) return 16'd0;
         if (num >= den) return 16'hFFFF;
         quot = (160'(num) << 32) / 160'(den);
         q = quot[31:0];
         root = 0;
         for (int b = 15; b >= 0; b--) begin
            t = root | (32'd1 << b);
            if (64'(t) * 64'(t) <= 64'(q)) root = t;
         end
         return root[15:0];
      endfunction

      function void note_sample(req_payload_type s);
         int unsigned len;
         longint ci, cq, pi, pq;
         rsp_payload_type r;
         len = sym_len < 2 ? 2 : (sym_len > MAX_LEN ? MAX_LEN : sym_len);
         if (pos >= len) pos = 0;
         ci = s.sample_i;
         cq = s.sample_q;
         if (have_prev) begin
            pi = prev_i[pos];
            pq = prev_q[pos];
            dot_re += pi * ci + pq * cq;
            dot_im += pq * ci - pi * cq;
         end
         e_cur += 64'(ci * ci + cq * cq);
         prev_i[pos] = s.sample_i;
         prev_q[pos] = s.sample_q;
         if (pos + 1 >= len) begin
            if (have_prev) begin
               r.correlation = correlation_of();
               r.detected = r.correlation >= thr;
               pending.push_back(r);
            end
            e_prev = e_cur;
            e_cur = 0;
            dot_re = 0;
            dot_im = 0;
            have_prev = 1;
            pos = 0;
         end else begin
            pos++;
         end
      endfunction

      function void check(rsp_payload_type got);
         rsp_payload_type want;
         if (pending.size() == 0) begin
            $error("unexpected result word correlation %0d", got.correlation);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.correlation !== want.correlation) begin
            $error("correlation expected %0d actual %0d", want.correlation, got.correlation);
            errors++;
         end
         if (got.detected !== want.detected) begin
            $error("detected expected %0d actual %0d", want.detected, got.detected);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset;
   logic req_valid, req_stall;
   req_payload_type req_payload;
   logic rsp_valid, rsp_stall;
   rsp_payload_type rsp_payload;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   corr_scoreboard sb = new();
   int gap_pct = 25;
   int stall_pct = 49;
   bit hold_req = 0;
   bit hold_seen = 0;
   int hold_left = 0;

   // stimulus side copy of the last symbol, used to build correlated symbols
   logic signed [15:0] gen_i [MAX_LEN] = '{default: '0};
   logic signed [15:0] gen_q [MAX_LEN] = '{default: '0};
   int unsigned gen_len = SYMBOL_LENGTH_RESET;
   int unsigned gen_pos = 0;
   int gen_mode = 0;

   symbol_autocorr_preamble_detect i_dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= 3000;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= $urandom_range(0, 99) < stall_pct;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_payload);
   end

   task automatic send_sample(logic signed [15:0] si, logic signed [15:0] sq);
      req_payload_type w;
      w.sample_i = si;
      w.sample_q = sq;
      if ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1;
      req_payload <= w;
      do @(posedge clock); while (req_stall);
      sb.note_sample(w);
   endtask

   task automatic stop_sending();
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      req_valid <= 0;
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.write_reg(idx, val);
      if (idx == REG_SYMBOL_LENGTH) begin
         gen_len = val & 16'h1FFF;
         gen_len = gen_len < 2 ? 2 : (gen_len > MAX_LEN ? MAX_LEN : gen_len);
         gen_pos = 0;
      end
      @(posedge clock);
   endtask

   task automatic drain();
      stop_sending();
      while (sb.pending.size() != 0) @(posedge clock);
      // the tail of an unfinished symbol may still be in the multiply loop
      repeat (100) @(posedge clock);
   endtask

   task automatic send_random(int n);
      logic signed [15:0] si, sq;
      for (int k = 0; k < n; k++) begin
         if (gen_pos == 0) gen_mode = $urandom_range(0, 9);
         case (gen_mode)
            0, 1: begin
               si = 16'($urandom);
               sq = 16'($urandom);
            end
            2, 3: begin
               si = gen_i[gen_pos];
               sq = gen_q[gen_pos];
            end
            4: begin
               si = -gen_q[gen_pos];
               sq = gen_i[gen_pos];
            end
            5, 6: begin
               si = 16'(gen_i[gen_pos] + $signed($urandom_range(0, 15)) - 8);
               sq = 16'(gen_q[gen_pos] + $signed($urandom_range(0, 15)) - 8);
            end
            7: begin
               si = 16'($signed($urandom_range(0, 6)) - 3);
               sq = 16'($signed($urandom_range(0, 6)) - 3);
            end
            8: begin
               si = 0;
               sq = 0;
            end
            default: begin
               si = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
               sq = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end
         endcase
         gen_i[gen_pos] = si;
         gen_q[gen_pos] = sq;
         gen_pos = gen_pos + 1 >= gen_len ? 0 : gen_pos + 1;
         send_sample(si, sq);
      end
   endtask

   task automatic set_pace(int phase);
      case (phase % 3)
         0: begin gap_pct = 25; stall_pct = 49; end
         1: begin gap_pct = 49; stall_pct = 25; end
         default: begin gap_pct = 0; stall_pct = 0; end
      endcase
   endtask

   task automatic random_phase(int phase, logic [15:0] len_word, logic [15:0] thr_word, int n);
      drain();
      set_pace(phase);
      csr_write(REG_SYMBOL_LENGTH, len_word);
      csr_write(REG_DETECT_THRESHOLD, thr_word);
      send_random(n);
   endtask

   initial begin
      reset <= 1;
      req_valid <= 0;
      req_payload <= '0;
      csr_valid <= 0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 0;

      // length 2, threshold 0: zero energy, full correlation, extremes
      csr_write(REG_SYMBOL_LENGTH, 16'd0);
      csr_write(REG_DETECT_THRESHOLD, 16'd0);
      send_sample(16'sd0, 16'sd0);       send_sample(16'sd0, 16'sd0);
      send_sample(16'sd0, 16'sd0);       send_sample(16'sd0, 16'sd0);
      send_sample(16'sh7FFF, 16'sh8000); send_sample(16'sh8000, 16'sh7FFF);
      send_sample(16'sh7FFF, 16'sh8000); send_sample(16'sh8000, 16'sh7FFF);
      send_sample(16'sh8000, 16'sh8000); send_sample(16'sh7FFF, 16'sh7FFF);
      send_sample(16'sd1, 16'sd0);       send_sample(16'sd0, 16'sd1);
      send_sample(16'sd0, -16'sd1);      send_sample(16'sd1, 16'sd0);
      send_sample(-16'sd1, -16'sd1);     send_sample(16'sd5, -16'sd3);

      // reset values of both registers, via an explicit default length
      drain();
      set_pace(0);
      csr_write(REG_SYMBOL_LENGTH, SYMBOL_LENGTH_RESET);
      csr_write(REG_DETECT_THRESHOLD, THRESHOLD_RESET);
      send_random(700);

      random_phase(1, 16'd1, 16'hFFFF, 150);
      drain();
      csr_write(8'd2, 16'hFFFF);
      csr_write(8'hFF, 16'h0000);
      set_pace(2);
      send_random(100);

      // long receiver hold-off with a short symbol so the block backs up
      random_phase(2, 16'hE003, 16'd30000, 30);
      hold_req = ~hold_req;
      send_random(240);

      random_phase(3, 16'd7, 16'($urandom), 120);
      random_phase(4, 16'd16, THRESHOLD_RESET, 160);
      random_phase(5, 16'd5, 16'd0, 100);
      random_phase(6, 16'd2, 16'd32768, 100);
      // threshold change alone keeps the framing
      drain();
      csr_write(REG_DETECT_THRESHOLD, 16'd50000);
      set_pace(7);
      send_random(81);
      random_phase(8, 16'd13, 16'($urandom), 130);
      random_phase(9, 16'd8191, 16'($urandom), 100);

      stop_sending();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

endmodule

[symbol_autocorr_preamble_detect.f]
hdl/sapd_pkg.sv
hdl/sapd_ram.sv
hdl/sapd_dpath.sv
hdl/sapd_ctrl.sv
hdl/symbol_autocorr_preamble_detect.sv
test/tb_symbol_autocorr_preamble_detect.sv
